// ----- hdl/chacha_pkg.sv -----
package chacha_pkg;

   // number of double rounds per keystream block (1 to 16)
   localparam int DOUBLE_ROUNDS = 10;

   // register file geometry
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_KEY_PART_0    = 3'd0;
   localparam logic [2:0] REG_KEY_PART_1    = 3'd1;
   localparam logic [2:0] REG_KEY_PART_2    = 3'd2;
   localparam logic [2:0] REG_KEY_PART_3    = 3'd3;
   localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
   localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
   localparam logic [2:0] REG_START_COUNTER = 3'd6;

   // "expand 32-byte k"
   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   // word indexes touched by one quarter round
   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
      logic [3:0] c;
      logic [3:0] d;
   } qr_words_type;

   // four column rounds, then four diagonal rounds
   localparam qr_words_type QR_WORDS [8] = '{
      '{a: 4'd0, b: 4'd4, c: 4'd8,  d: 4'd12},
      '{a: 4'd1, b: 4'd5, c: 4'd9,  d: 4'd13},
      '{a: 4'd2, b: 4'd6, c: 4'd10, d: 4'd14},
      '{a: 4'd3, b: 4'd7, c: 4'd11, d: 4'd15},
      '{a: 4'd0, b: 4'd5, c: 4'd10, d: 4'd15},
      '{a: 4'd1, b: 4'd6, c: 4'd11, d: 4'd12},
      '{a: 4'd2, b: 4'd7, c: 4'd8,  d: 4'd13},
      '{a: 4'd3, b: 4'd4, c: 4'd9,  d: 4'd14}
   };

endpackage

// ----- hdl/chacha20_stream_cipher_core.sv -----
// ChaCha20 byte-stream cipher core.
// Requests arrive on the req_ stream, one data byte each, with a restart flag
// in req_tuser. Each request yields exactly one response byte on rsp_, equal
// to the data byte XORed with the next keystream byte.
// Key, nonce and start counter are written through the csr_ port; the user must
// do so only while the core is idle, as the core does not enforce it. A request
// with restart set reloads the block counter from start_counter and drops any
// keystream left in the current block. The core handles one request at a time;
// req_tready is high only when idle. A byte from the current block passes from
// FETCH, which reads its keystream word, to OUTPUT, which registers the response.
// A byte that needs a new block first runs the block generator: a state load of
// 16 words, then 64 add or xor-rotate steps per double round on the shared 32-bit
// unit, each a read state and a write state, for 10 double rounds, and a final add
// of the 16 words; the byte then goes through FETCH and OUTPUT as above. One block
// serves 64 bytes.
// The round words live in a 16-entry memory with two registered read ports, which
// sets the read state and write state of each step.
// A stalled rsp_ holds the finished response; the next request is still
// accepted and waits only for the response register to free up.
// Reset clears the configuration and control registers and marks the keystream empty.
module chacha20_stream_cipher_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tuser,  // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [7:0] cipher_byte
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [chacha_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [chacha_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [chacha_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);
   import chacha_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_RND_RD = 3'd2;
   localparam logic [2:0] ST_RND_WR = 3'd3;
   localparam logic [2:0] ST_FIN_RD = 3'd4;
   localparam logic [2:0] ST_FIN_WR = 3'd5;
   localparam logic [2:0] ST_FETCH  = 3'd6;
   localparam logic [2:0] ST_OUTPUT = 3'd7;

   localparam logic [3:0] LAST_DR = 4'(DOUBLE_ROUNDS - 1);

   // configuration registers
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_lo_ff;
   logic [31:0] nonce_hi_ff, start_ctr_ff;
   logic [2:0]  csr_index;
   logic        csr_wr;

   // control and payload
   logic [2:0]  state_ff, state_in;
   logic [6:0]  pos_ff, pos_in;
   logic [31:0] counter_ff, counter_in;
   logic [7:0]  data_ff, data_in;
   logic [5:0]  uop_ff, uop_in;
   logic [3:0]  dr_ff, dr_in;
   logic [3:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   // round word memory
   logic [31:0] round_mem [16];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic        mem_we;
   logic [3:0]  mem_wa, mem_ra, mem_rb;
   logic [31:0] mem_wd;

   // step unit
   qr_words_type qw;
   logic [2:0]   step;
   logic [3:0]   op_p, op_q;
   logic [31:0]  mix, step_res;
   logic [31:0]  init_word;
   logic [7:0]   ks_byte;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      unique case (csr_index)
         REG_KEY_PART_0:    csr_prdata = key0_ff;
         REG_KEY_PART_1:    csr_prdata = key1_ff;
         REG_KEY_PART_2:    csr_prdata = key2_ff;
         REG_KEY_PART_3:    csr_prdata = key3_ff;
         REG_NONCE_LOW:     csr_prdata = nonce_lo_ff;
         REG_NONCE_HIGH:    csr_prdata = {32'd0, nonce_hi_ff};
         REG_START_COUNTER: csr_prdata = {32'd0, start_ctr_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         start_ctr_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_KEY_PART_0:    key0_ff      <= csr_pwdata;
            REG_KEY_PART_1:    key1_ff      <= csr_pwdata;
            REG_KEY_PART_2:    key2_ff      <= csr_pwdata;
            REG_KEY_PART_3:    key3_ff      <= csr_pwdata;
            REG_NONCE_LOW:     nonce_lo_ff  <= csr_pwdata;
            REG_NONCE_HIGH:    nonce_hi_ff  <= csr_pwdata[31:0];
            REG_START_COUNTER: start_ctr_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // initial state word selected by idx
   always_comb begin
      unique case (idx_ff)
         4'd0:  init_word = SIGMA_0;
         4'd1:  init_word = SIGMA_1;
         4'd2:  init_word = SIGMA_2;
         4'd3:  init_word = SIGMA_3;
         4'd4:  init_word = key0_ff[31:0];
         4'd5:  init_word = key0_ff[63:32];
         4'd6:  init_word = key1_ff[31:0];
         4'd7:  init_word = key1_ff[63:32];
         4'd8:  init_word = key2_ff[31:0];
         4'd9:  init_word = key2_ff[63:32];
         4'd10: init_word = key3_ff[31:0];
         4'd11: init_word = key3_ff[63:32];
         4'd12: init_word = counter_ff;
         4'd13: init_word = nonce_lo_ff[31:0];
         4'd14: init_word = nonce_lo_ff[63:32];
         4'd15: init_word = nonce_hi_ff;
         default: init_word = '0;
      endcase
   end

   // quarter-round micro-op decode: even steps add, odd steps xor-rotate
   assign qw   = QR_WORDS[uop_ff[5:3]];
   assign step = uop_ff[2:0];

   always_comb begin
      unique case (step)
         3'd0, 3'd4: begin op_p = qw.a; op_q = qw.b; end
         3'd1, 3'd5: begin op_p = qw.d; op_q = qw.a; end
         3'd2, 3'd6: begin op_p = qw.c; op_q = qw.d; end
         default:    begin op_p = qw.b; op_q = qw.c; end
      endcase
   end

   assign mix = rd_a_ff ^ rd_b_ff;

   always_comb begin
      if (!step[0]) begin
         step_res = rd_a_ff + rd_b_ff;
      end else begin
         unique case (step[2:1])
            2'd0:    step_res = {mix[15:0], mix[31:16]};
            2'd1:    step_res = {mix[19:0], mix[31:20]};
            2'd2:    step_res = {mix[23:0], mix[31:24]};
            default: step_res = {mix[24:0], mix[31:25]};
         endcase
      end
   end

   // keystream byte from the word read at pos
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0:    ks_byte = rd_a_ff[7:0];
         2'd1:    ks_byte = rd_a_ff[15:8];
         2'd2:    ks_byte = rd_a_ff[23:16];
         default: ks_byte = rd_a_ff[31:24];
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      counter_in   = counter_ff;
      data_in      = data_ff;
      uop_in       = uop_ff;
      dr_in        = dr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = init_word;
      mem_ra       = pos_ff[5:2];
      mem_rb       = op_q;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               data_in = req_tdata;
               idx_in  = '0;
               if (req_tuser) begin
                  counter_in = start_ctr_ff;
                  pos_in     = 7'd64;
               end
               state_in = (req_tuser | pos_ff[6]) ? ST_LOAD : ST_FETCH;
            end
         end
         ST_LOAD: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               uop_in   = '0;
               dr_in    = '0;
               state_in = ST_RND_RD;
            end
         end
         ST_RND_RD: begin
            mem_ra   = op_p;
            state_in = ST_RND_WR;
         end
         ST_RND_WR: begin
            mem_ra = op_p;
            mem_we = 1'b1;
            mem_wa = op_p;
            mem_wd = step_res;
            uop_in = uop_ff + 6'd1;
            if (uop_ff == 6'd63 && dr_ff == LAST_DR) begin
               idx_in   = '0;
               state_in = ST_FIN_RD;
            end else begin
               if (uop_ff == 6'd63) begin
                  dr_in = dr_ff + 4'd1;
               end
               state_in = ST_RND_RD;
            end
         end
         ST_FIN_RD: begin
            mem_ra   = idx_ff;
            state_in = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            mem_ra = idx_ff;
            mem_we = 1'b1;
            mem_wd = rd_a_ff + init_word;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               counter_in = counter_ff + 32'd1;
               pos_in     = '0;
               state_in   = ST_FETCH;
            end else begin
               state_in = ST_FIN_RD;
            end
         end
         ST_FETCH: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ ks_byte;
               pos_in       = pos_ff + 7'd1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // round word memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         round_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= round_mem[mem_ra];
      rd_b_ff <= round_mem[mem_rb];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 7'd64;
         counter_ff   <= '0;
         uop_ff       <= '0;
         dr_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         counter_ff   <= counter_in;
         uop_ff       <= uop_in;
         dr_ff        <= dr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
